@@ rtl/tsol_pkg.sv @@
// ----------------------------------------------------------------------------
// tsol_pkg: shared types and codes for the transpose self-organizing list
// Command and status codes, field widths and stream word layouts.
// ----------------------------------------------------------------------------
package tsol_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned COUNT_W  = 5;

    // input beat: cmd, key, zero pad to whole bytes
    localparam int unsigned IN_DATA_W  = 40;
    // output beat: status, found_position, entry_count, zero pad
    localparam int unsigned OUT_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

endpackage

@@ rtl/tsol_ram.sv @@
// ----------------------------------------------------------------------------
// tsol_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tsol_ram #(
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/transpose_self_organizing_list_core.sv @@
// ----------------------------------------------------------------------------
// transpose_self_organizing_list_core: list of keys with transpose-on-hit
// Array-backed ordered key list taking insert, remove and search commands.
// ----------------------------------------------------------------------------
// The list holds up to DEPTH 32-bit keys in a circular buffer inside one RAM:
// a head pointer marks position 0, so insert at the front only moves the head
// back one slot and writes the key, and remove from the back only shortens the
// list. A search walks the list from the head with one shared 32-bit equality
// compare: every position passes through a RAM read state, then a compare on
// the registered read data, and a hit at position 1 or later adds a swap state
// for the second write of the swap. One result beat comes out per command;
// the input is not ready while a command is in work or while a result beat
// waits on the output, so a new command is not taken before the last result
// beat has been accepted. Command code three is taken and answered with
// status done and no change to the list.
module transpose_self_organizing_list_core
    import tsol_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // [1:0] cmd, [33:2] key, [39:34] zero
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata   // [1:0] status, [5:2] found_position,
                                                   // [10:6] entry_count, [15:11] zero
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned LW = $clog2(DEPTH + 1);
    localparam logic [AW:0] DEPTH_A = (AW + 1)'(DEPTH);
    localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_SWAP
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_head;
    logic [LW-1:0]   r_len;
    logic [AW-1:0]   r_pos;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_prev;
    logic            r_head_hit;

    logic                r_ovalid;
    t_status             r_ostatus;
    logic [POS_W-1:0]    r_opos;
    logic [COUNT_W-1:0]  r_ocount;

    // input fields
    t_cmd              in_cmd;
    logic signed [KEY_W-1:0] in_key;
    logic              in_acc;

    assign in_cmd = t_cmd'(i_s_axis_tdata[CMD_W-1:0]);
    assign in_key = i_s_axis_tdata[CMD_W +: KEY_W];
    assign o_s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // shared position-to-slot adder
    logic [AW-1:0] pos_sel;
    logic [AW:0]   slot_sum;
    logic [AW-1:0] slot;
    logic [AW-1:0] head_dec;

    always_comb begin
        pos_sel = (r_state == S_CMP) ? r_pos - AW'(1) : r_pos;
        slot_sum = {1'b0, r_head} + {1'b0, pos_sel};
        if (slot_sum >= DEPTH_A) begin
            slot_sum = slot_sum - DEPTH_A;
        end
        slot = slot_sum[AW-1:0];
        head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    end

    // list storage
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [KEY_W-1:0]  ram_rdata;
    logic              cmp_hit;
    logic              last_pos;

    assign cmp_hit  = (ram_rdata == r_key);
    assign last_pos = ({1'b0, r_pos} == (AW + 1)'(r_len - LW'(1)));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot;
        ram_wdata = r_prev;
        case (r_state)
            S_IDLE: begin
                ram_waddr = head_dec;
                ram_wdata = in_key;
                ram_we    = in_acc && (in_cmd == CMD_INSERT) && (r_len != DEPTH_L);
            end
            S_CMP: begin
                // first half of the swap: hit moves one place forward
                ram_wdata = ram_rdata;
                ram_we    = (r_pos != '0) && cmp_hit;
            end
            S_SWAP: begin
                // second half: former predecessor moves back
                ram_wdata = r_prev;
                ram_we    = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    tsol_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH),
        .ADDR_W(AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(slot),
        .o_rdata(ram_rdata)
    );

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_len    <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_key  <= in_key;
                        r_opos <= '0;
                        case (in_cmd)
                            CMD_INSERT: begin
                                r_ovalid <= 1'b1;
                                if (r_len == DEPTH_L) begin
                                    r_ostatus <= ST_FULL;
                                    r_ocount  <= COUNT_W'(r_len);
                                end else begin
                                    r_head    <= head_dec;
                                    r_len     <= r_len + LW'(1);
                                    r_ostatus <= ST_DONE;
                                    r_ocount  <= COUNT_W'(r_len + LW'(1));
                                end
                            end
                            CMD_REMOVE: begin
                                r_ovalid <= 1'b1;
                                if (r_len == '0) begin
                                    r_ostatus <= ST_EMPTY;
                                    r_ocount  <= '0;
                                end else begin
                                    r_len     <= r_len - LW'(1);
                                    r_ostatus <= ST_DONE;
                                    r_ocount  <= COUNT_W'(r_len - LW'(1));
                                end
                            end
                            CMD_SEARCH: begin
                                r_ocount <= COUNT_W'(r_len);
                                if (r_len == '0) begin
                                    r_ovalid  <= 1'b1;
                                    r_ostatus <= ST_EMPTY;
                                end else begin
                                    r_pos   <= '0;
                                    r_state <= S_READ;
                                end
                            end
                            default: begin
                                r_ovalid  <= 1'b1;
                                r_ostatus <= ST_DONE;
                                r_ocount  <= COUNT_W'(r_len);
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_pos == '0) begin
                        // remember head compare, resolve it only if nothing later hits
                        r_head_hit <= cmp_hit;
                        r_prev     <= ram_rdata;
                        if (last_pos) begin
                            r_ovalid  <= 1'b1;
                            r_ostatus <= cmp_hit ? ST_DONE : ST_MISS;
                            r_state   <= S_IDLE;
                        end else begin
                            r_pos   <= r_pos + AW'(1);
                            r_state <= S_READ;
                        end
                    end else if (cmp_hit) begin
                        r_state <= S_SWAP;
                    end else begin
                        r_prev <= ram_rdata;
                        if (last_pos) begin
                            r_ovalid  <= 1'b1;
                            r_ostatus <= r_head_hit ? ST_DONE : ST_MISS;
                            r_state   <= S_IDLE;
                        end else begin
                            r_pos   <= r_pos + AW'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                S_SWAP: begin
                    r_ovalid  <= 1'b1;
                    r_ostatus <= ST_DONE;
                    r_opos    <= POS_W'(r_pos);
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {(OUT_DATA_W - STATUS_W - POS_W - COUNT_W)'(0),
                              r_ocount, r_opos, r_ostatus};

endmodule
